@@ rtl/camera_point_projection_top_assert.svh @@
// Assertion macros for the projection block.
`ifndef CAMERA_POINT_PROJECTION_TOP_ASSERT_SVH
`define CAMERA_POINT_PROJECTION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CPP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CPP_ASSERT_IMPLY(label, ante, cons)
`define CPP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/cpp_pkg.sv @@
package cpp_pkg;

    localparam int COEFS = 12;
    localparam int DIV_STEPS = 17;
    localparam int REM_W = 81;
    localparam int IN_W = 144;
    localparam int OUT_W = 72;

    localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] quo;
        logic                 neg;
        logic                 ovf;
    } t_lane;

    typedef struct packed {
        logic        zpos;
        logic [63:0] den;
        logic [31:0] depth;
    } t_meta;

endpackage

@@ rtl/camera_point_projection_top.sv @@
// A project item passes the row read, product, sum, divider and output registers in turn.
// Throughput: one item per cycle; load items produce no result.
// The stream stalls as a whole only while the output register is held.
// Reset (synchronous, active low) clears valid flags and the image size;
// the coefficient memory is not cleared and must be written before use.
module camera_point_projection_top #(
    parameter int FRAME_COUNT = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_addr,
    input  logic [13:0]               i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // frame, coef_index, coef_value, point_x, point_y, point_z, zero fill
    input  logic [cpp_pkg::IN_W-1:0]  s_axis_tdata,
    // mode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // visible, pixel_x, pixel_y, depth, zero fill
    output logic [cpp_pkg::OUT_W-1:0] m_axis_tdata
);
    import cpp_pkg::*;

    localparam int FA = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

    logic               w_en;
    logic [5:0]         w_frame;
    logic [3:0]         w_ci;
    logic [FA-1:0]      w_addr;
    logic               w_frame_ok;

    logic [31:0]        mem [FRAME_COUNT][COEFS];

    logic [13:0]        r_width, r_height;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic [DIV_STEPS-1:0] r_dv;
    logic               r_out_valid;

    logic [31:0]        r_row [COEFS];
    logic               r_fok;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [63:0] r_prod [COEFS];
    logic signed [63:0] r_sx, r_sy, r_sz;
    t_lane              r_lx [DIV_STEPS+1];
    t_lane              r_ly [DIV_STEPS+1];
    t_meta              r_meta [DIV_STEPS+1];
    t_lane              n_lx [DIV_STEPS+1];
    t_lane              n_ly [DIV_STEPS+1];
    logic [OUT_W-1:0]   r_out;

    logic signed [63:0] w_m3 [3];
    logic signed [63:0] w_zsh;
    logic [31:0]        w_depth;
    logic [63:0]        w_absx, w_absy, w_nx, w_ny, w_den;
    logic [REM_W-1:0]   w_lim;
    logic [15:0]        w_pixx, w_pixy;
    logic               w_vis;

    assign w_en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;
    assign w_frame = s_axis_tdata[5:0];
    assign w_ci = s_axis_tdata[9:6];
    assign w_addr = FA'(w_frame);
    assign w_frame_ok = 32'(w_frame) < FRAME_COUNT;

    always_ff @(posedge i_clk) begin
        if (w_en && s_axis_tvalid && !s_axis_tuser && w_frame_ok && (w_ci < 4'(COEFS))) begin
            mem[w_addr][w_ci] <= s_axis_tdata[41:10];
        end
        if (w_en) begin
            r_row <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
            r_height <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_dv <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_IMAGE_WIDTH: r_width <= i_cfg_wdata;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_en) begin
                r_v1 <= s_axis_tvalid && s_axis_tuser;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_dv <= {r_dv[DIV_STEPS-2:0], r_v4};
                r_out_valid <= r_dv[DIV_STEPS-1];
            end
        end
    end

    always_comb begin
        t_lane fx, fy;
        for (int r = 0; r < 3; r++) begin
            w_m3[r] = r_prod[4*r+3] <<< 14;
        end
        w_zsh = r_sz >>> 14;
        if (w_zsh > 64'sh7FFF_FFFF) begin
            w_depth = 32'h7FFF_FFFF;
        end else if (w_zsh < -64'sh8000_0000) begin
            w_depth = 32'h8000_0000;
        end else begin
            w_depth = w_zsh[31:0];
        end
        w_absx = r_sx[63] ? 64'(-r_sx) : 64'(r_sx);
        w_absy = r_sy[63] ? 64'(-r_sy) : 64'(r_sy);
        w_nx = {w_absx[62:0], 1'b0} + 64'(r_sz);
        w_ny = {w_absy[62:0], 1'b0} + 64'(r_sz);
        w_den = {r_sz[62:0], 1'b0};
        w_lim = {17'b0, w_den} << DIV_STEPS;
        n_lx[0].rem = {17'b0, w_nx};
        n_lx[0].quo = '0;
        n_lx[0].neg = r_sx[63];
        n_lx[0].ovf = {17'b0, w_nx} >= w_lim;
        n_ly[0].rem = {17'b0, w_ny};
        n_ly[0].quo = '0;
        n_ly[0].neg = r_sy[63];
        n_ly[0].ovf = {17'b0, w_ny} >= w_lim;
        for (int j = 0; j < DIV_STEPS; j++) begin
            n_lx[j+1] = r_lx[j];
            n_ly[j+1] = r_ly[j];
            if (r_lx[j].rem >= ({17'b0, r_meta[j].den} << (DIV_STEPS-1-j))) begin
                n_lx[j+1].rem = r_lx[j].rem - ({17'b0, r_meta[j].den} << (DIV_STEPS-1-j));
                n_lx[j+1].quo[DIV_STEPS-1-j] = 1'b1;
            end
            if (r_ly[j].rem >= ({17'b0, r_meta[j].den} << (DIV_STEPS-1-j))) begin
                n_ly[j+1].rem = r_ly[j].rem - ({17'b0, r_meta[j].den} << (DIV_STEPS-1-j));
                n_ly[j+1].quo[DIV_STEPS-1-j] = 1'b1;
            end
        end
        fx = r_lx[DIV_STEPS];
        fy = r_ly[DIV_STEPS];
        if (!r_meta[DIV_STEPS].zpos) begin
            w_pixx = '0;
        end else if (fx.neg) begin
            w_pixx = (fx.ovf || fx.quo > 17'd32768) ? 16'h8000 : 16'(-fx.quo);
        end else begin
            w_pixx = (fx.ovf || fx.quo > 17'd32767) ? 16'h7FFF : fx.quo[15:0];
        end
        if (!r_meta[DIV_STEPS].zpos) begin
            w_pixy = '0;
        end else if (fy.neg) begin
            w_pixy = (fy.ovf || fy.quo > 17'd32768) ? 16'h8000 : 16'(-fy.quo);
        end else begin
            w_pixy = (fy.ovf || fy.quo > 17'd32767) ? 16'h7FFF : fy.quo[15:0];
        end
        w_vis = r_meta[DIV_STEPS].zpos && !w_pixx[15] && !w_pixy[15]
             && ({1'b0, w_pixx[14:0]} < {2'b0, r_width})
             && ({1'b0, w_pixy[14:0]} < {2'b0, r_height});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fok <= w_frame_ok;
            r_px <= s_axis_tdata[73:42];
            r_py <= s_axis_tdata[105:74];
            r_pz <= s_axis_tdata[137:106];
            for (int r = 0; r < 3; r++) begin
                r_prod[4*r]   <= r_fok ? $signed(r_row[4*r]) * r_px : 64'sd0;
                r_prod[4*r+1] <= r_fok ? $signed(r_row[4*r+1]) * r_py : 64'sd0;
                r_prod[4*r+2] <= r_fok ? $signed(r_row[4*r+2]) * r_pz : 64'sd0;
                r_prod[4*r+3] <= r_fok ? 64'($signed(r_row[4*r+3])) : 64'sd0;
            end
            r_sx <= (r_prod[0] >>> 2) + (r_prod[1] >>> 2) + (r_prod[2] >>> 2) + w_m3[0];
            r_sy <= (r_prod[4] >>> 2) + (r_prod[5] >>> 2) + (r_prod[6] >>> 2) + w_m3[1];
            r_sz <= (r_prod[8] >>> 2) + (r_prod[9] >>> 2) + (r_prod[10] >>> 2) + w_m3[2];
            r_meta[0].zpos <= r_sz > 64'sd0;
            r_meta[0].den <= w_den;
            r_meta[0].depth <= w_depth;
            for (int j = 0; j <= DIV_STEPS; j++) begin
                r_lx[j] <= n_lx[j];
                r_ly[j] <= n_ly[j];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_meta[j+1] <= r_meta[j];
            end
            r_out <= {7'b0, r_meta[DIV_STEPS].depth, w_pixy, w_pixx, w_vis};
        end
    end

    `include "camera_point_projection_top_assert.svh"

    `CPP_ASSERT_IMPLY(a_vis_pix_x, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[16])
    `CPP_ASSERT_IMPLY(a_vis_depth, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[64])
    `CPP_ASSERT_NEXT(a_reset_empty, !i_rst_n, !m_axis_tvalid)

endmodule

@@ bench/tb_camera_point_projection_top.sv @@
`timescale 1ns / 1ps

module tb_camera_point_projection_top;

    localparam int FRAMES = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic        vis;
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] dep;
    } t_pixel;

    typedef struct {
        logic        mode;
        logic [5:0]  frame;
        logic [3:0]  idx;
        logic [31:0] coef;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        typed;
        t_pixel      res;
    } t_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [1:0]                i_cfg_addr = '0;
    logic [13:0]               i_cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [cpp_pkg::IN_W-1:0]  s_axis_tdata = '0;
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [cpp_pkg::OUT_W-1:0] m_axis_tdata;

    camera_point_projection_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] coef_mem [FRAMES*12];
    logic [11:0] loaded [FRAMES];
    logic [13:0] img_w, img_h;
    t_pixel      pending_pixels [$];
    t_row        table_rows [$];
    int          errors = 0;
    int          mismatches = 0;
    int          projects = 0;
    int          loads = 0;
    int          results = 0;
    int          idle_count = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          holding = 1'b0;

    function automatic logic signed [15:0] round_sat(longint signed n, longint signed d);
        longint unsigned mag, q;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = (2 * mag + d) / (2 * longint'(d));
        if (n < 0)
            return (q > 32768) ? -16'sd32768 : -16'(q);
        return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    function automatic t_pixel project_point(logic [5:0] f, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
        longint signed acc [3];
        longint signed dep;
        logic signed [15:0] pxs, pys;
        t_pixel r;
        for (int row = 0; row < 3; row++) begin
            acc[row] = ((longint'($signed(coef_mem[f*12+row*4])) * $signed(x)) >>> 2)
                     + ((longint'($signed(coef_mem[f*12+row*4+1])) * $signed(y)) >>> 2)
                     + ((longint'($signed(coef_mem[f*12+row*4+2])) * $signed(z)) >>> 2)
                     + longint'($signed(coef_mem[f*12+row*4+3])) * 16384;
        end
        dep = acc[2] >>> 14;
        if (dep > 64'sh7FFF_FFFF)
            dep = 64'sh7FFF_FFFF;
        if (dep < -64'sh8000_0000)
            dep = -64'sh8000_0000;
        r.dep = dep[31:0];
        r.vis = 1'b0;
        r.px = '0;
        r.py = '0;
        if (acc[2] > 0) begin
            pxs = round_sat(acc[0], acc[2]);
            pys = round_sat(acc[1], acc[2]);
            r.px = pxs;
            r.py = pys;
            r.vis = pxs >= 0 && pxs < $signed({3'b0, img_w}) &&
                    pys >= 0 && pys < $signed({3'b0, img_h});
        end
        return r;
    endfunction

    task automatic write_reg(logic [1:0] addr, logic [13:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = val;
        if (addr == cpp_pkg::CFG_IMAGE_WIDTH)
            img_w = val;
        else if (addr == cpp_pkg::CFG_IMAGE_HEIGHT)
            img_h = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_item(t_row r);
        t_pixel p;
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = r.mode;
        s_axis_tdata = {6'b0, r.z, r.y, r.x, r.coef, r.idx, r.frame};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (r.mode == MODE_LOAD) begin
            loads++;
            if (r.idx < 12) begin
                coef_mem[r.frame*12+r.idx] = r.coef;
                loaded[r.frame][r.idx] = 1'b1;
            end
        end else begin
            projects++;
            p = project_point(r.frame, r.x, r.y, r.z);
            pending_pixels.push_back(r.typed ? r.res : p);
        end
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'h0}
                          + ($urandom_range(0, 700) << 16) + $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic t_row rand_item();
        t_row r;
        r.typed = 1'b0;
        r.coef = rand_q();
        r.x = rand_q();
        r.y = rand_q();
        r.z = rand_q();
        if ($urandom_range(0, 99) < 55) begin
            r.mode = MODE_LOAD;
            r.frame = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 7));
            r.idx = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                                 : 4'($urandom_range(0, 11));
            if ($urandom_range(0, 2) == 0)
                r.coef = $signed(Q_ONE) * $signed($urandom_range(0, 4)) - Q_ONE * 2;
        end else begin
            r.mode = MODE_PROJECT;
            r.frame = 6'($urandom_range(0, 63));
            if (loaded[r.frame] != 12'hFFF)
                r.frame = 6'($urandom_range(0, 7));
            if (loaded[r.frame] != 12'hFFF)
                r.frame = '0;
        end
        return r;
    endfunction

    function automatic t_row mk(logic mode, logic [5:0] f, logic [3:0] idx, logic [31:0] c,
                                logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic typed, t_pixel res);
        t_row r;
        r.mode = mode;
        r.frame = f;
        r.idx = idx;
        r.coef = c;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (hold_req && !holding) begin
            holding <= 1'b1;
            m_axis_tready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++)
                @(negedge i_clk);
            holding <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge i_clk) begin
        t_pixel want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.vis = m_axis_tdata[0];
            got.px = m_axis_tdata[16:1];
            got.py = m_axis_tdata[32:17];
            got.dep = m_axis_tdata[64:33];
            results++;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("Unexpected result item: %h", m_axis_tdata);
            end else begin
                want = pending_pixels.pop_front();
                if (got != want) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected vis=%0d x=%0d y=%0d depth=%h, ",
                                  "got vis=%0d x=%0d y=%0d depth=%h"},
                                 want.vis, $signed(want.px), $signed(want.py), want.dep,
                                 got.vis, $signed(got.px), $signed(got.py), got.dep);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_pixel none;
        logic [13:0] widths [4];
        logic [13:0] heights [4];
        none = '{1'b0, 16'h0, 16'h0, 32'h0};
        widths = '{14'd640, 14'd0, 14'd16383, 14'd1};
        heights = '{14'd480, 14'd0, 14'd16383, 14'd1};
        img_w = '0;
        img_h = '0;
        for (int f = 0; f < FRAMES; f++)
            loaded[f] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < 12; i++)
            table_rows.push_back(mk(MODE_LOAD, 6'd0, 4'(i), (i % 5 == 0) ? Q_ONE : 32'h0,
                                    '0, '0, '0, 1'b0, none));
        table_rows.push_back(mk(MODE_LOAD, 6'd0, 4'd13, 32'hDEAD_BEEF, '0, '0, '0, 1'b0, none));
        table_rows.push_back(mk(MODE_LOAD, 6'd63, 4'd11, 32'h8000_0000, '0, '0, '0, 1'b0, none));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd15, '0, 32'd10 << 16, 32'd20 << 16,
                                Q_ONE, 1'b1, '{1'b1, 16'd10, 16'd20, 32'h0001_0000}));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd0, '0, 32'd10 << 16, 32'd20 << 16,
                                32'h0, 1'b1, none));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd0, '0, 32'd10 << 16, 32'd20 << 16,
                                32'hFFFF_0000, 1'b1, '{1'b0, 16'h0, 16'h0, 32'hFFFF_0000}));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd0, '0, 32'h7FFF_FFFF, 32'h8000_0000,
                                Q_ONE, 1'b1, '{1'b0, 16'h7FFF, 16'h8000, 32'h0001_0000}));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd0, '0, 32'h0000_8000, 32'hFFFF_8000,
                                Q_ONE, 1'b1, '{1'b0, 16'h0001, 16'hFFFF, 32'h0001_0000}));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd0, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 1'b0, none));
        table_rows.push_back(mk(MODE_PROJECT, 6'd0, 4'd0, '0, 32'd639 << 16, 32'd479 << 16,
                                Q_ONE, 1'b0, none));

        for (int phase = 0; phase < 4; phase++) begin
            write_reg(cpp_pkg::CFG_IMAGE_WIDTH, widths[phase]);
            write_reg(cpp_pkg::CFG_IMAGE_HEIGHT, heights[phase]);
            write_reg(2'd2 + 2'(phase % 2), 14'($urandom));
            if (phase == 0)
                foreach (table_rows[i])
                    send_item(table_rows[i]);
            for (int n = 0; n < 285; n++) begin
                calm = (phase == 1 && n >= 100 && n < 200);
                if (phase == 2 && n == 50)
                    hold_req = 1'b1;
                send_item(rand_item());
            end
            calm = 1'b0;
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            drain();
        end

        $display("Covered %0d load items and %0d project items, %0d result items checked,",
                 loads, projects, results);
        $display("over four image sizes including zero and full range, with a long output stall.");
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d errors, %0d results outstanding.", errors, pending_pixels.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cpp_pkg.sv
rtl/camera_point_projection_top.sv
bench/tb_camera_point_projection_top.sv
